// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication that is disabled during reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Clocked implication that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

// ===== rtl/core/ralu_pkg.sv =====
// ---------------------------------------------------------------------------
// ralu_pkg
// Shared types and constants of the reduced rational arithmetic unit.
// ---------------------------------------------------------------------------
`default_nettype none
package ralu_pkg;
   localparam int OperandWidthDefault = 16;
   localparam int NumWidth = 33;
   localparam int DenWidth = 32;
   localparam int QueueDepth = 2;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } opcode_type;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_ZERO_DEN = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/core/rational_alu_reduced_unit.sv =====
// ---------------------------------------------------------------------------
// rational_alu_reduced_unit
// Rational add, subtract, multiply and divide with reduction to lowest terms.
// ---------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy stays high while
// the front part forms the raw products with one shared multiplier and hands
// the word to a two-entry queue, longer while that queue is full. The back
// part reduces it: a binary gcd, then two bit-serial divisions, so small
// operands finish sooner. The result shows for one cycle under rsp_valid and
// cannot be held off. A zero denominator gives status 1 with 0/0; a zero
// numerator gives 0/1.
`default_nettype none
module rational_alu_reduced_unit #(
   parameter int OPERAND_WIDTH = ralu_pkg::OperandWidthDefault
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [1:0]                   req_opcode,
   input  wire logic [OPERAND_WIDTH-1:0]     req_left_num,
   input  wire logic [OPERAND_WIDTH-1:0]     req_left_den,
   input  wire logic [OPERAND_WIDTH-1:0]     req_right_num,
   input  wire logic [OPERAND_WIDTH-1:0]     req_right_den,
   output logic                              rsp_valid,
   output logic [ralu_pkg::NumWidth-1:0]     rsp_result_num,
   output logic [ralu_pkg::DenWidth-1:0]     rsp_result_den,
   output logic                              rsp_status
);
   import ralu_pkg::*;
   localparam int W = OPERAND_WIDTH;
   localparam int QW = (2 * W + 1) + 1 + 2 * W + 1 + 1;

   logic f_valid, f_ready, f_num_neg, f_den_neg, f_err;
   logic [2*W:0] f_num_mag;
   logic [2*W-1:0] f_den_mag;
   logic q_valid, q_ready;
   logic [QW-1:0] q_data;
   logic front_busy;

   // Front part: operand capture and raw products.
   ralu_front #(.OPERAND_WIDTH(W)) u_front (
      .clock(clock), .reset(reset), .start(start), .busy(front_busy),
      .req_opcode(req_opcode), .req_left_num(req_left_num),
      .req_left_den(req_left_den), .req_right_num(req_right_num),
      .req_right_den(req_right_den), .out_valid(f_valid), .out_ready(f_ready),
      .out_num_mag(f_num_mag), .out_num_neg(f_num_neg), .out_den_mag(f_den_mag),
      .out_den_neg(f_den_neg), .out_err(f_err)
   );

   // Queue between the two parts.
   ralu_queue #(.DATA_WIDTH(QW), .DEPTH(QueueDepth)) u_queue (
      .clock(clock), .reset(reset), .in_valid(f_valid), .in_ready(f_ready),
      .in_data({f_num_mag, f_num_neg, f_den_mag, f_den_neg, f_err}),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   // Back part: reduction and result.
   ralu_back #(.OPERAND_WIDTH(W)) u_back (
      .clock(clock), .reset(reset), .in_valid(q_valid), .in_ready(q_ready),
      .in_num_mag(q_data[QW-1 -: 2*W+1]), .in_num_neg(q_data[2*W+2]),
      .in_den_mag(q_data[2*W+1:2]), .in_den_neg(q_data[1]), .in_err(q_data[0]),
      .rsp_valid(rsp_valid), .rsp_result_num(rsp_result_num),
      .rsp_result_den(rsp_result_den), .rsp_status(rsp_status)
   );

   assign busy = front_busy;
endmodule
`default_nettype wire

// ===== rtl/core/ralu_front.sv =====
// ---------------------------------------------------------------------------
// ralu_front
// Forms the raw sign/magnitude numerator and denominator of one word with one
// shared multiplier, and flags the zero-denominator error case.
// ---------------------------------------------------------------------------
`default_nettype none
module ralu_front #(
   parameter int OPERAND_WIDTH = ralu_pkg::OperandWidthDefault
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [1:0]                 req_opcode,
   input  wire logic [OPERAND_WIDTH-1:0]   req_left_num,
   input  wire logic [OPERAND_WIDTH-1:0]   req_left_den,
   input  wire logic [OPERAND_WIDTH-1:0]   req_right_num,
   input  wire logic [OPERAND_WIDTH-1:0]   req_right_den,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output logic [2*OPERAND_WIDTH:0]        out_num_mag,
   output logic                            out_num_neg,
   output logic [2*OPERAND_WIDTH-1:0]      out_den_mag,
   output logic                            out_den_neg,
   output logic                            out_err
);
   import ralu_pkg::*;
   localparam int W = OPERAND_WIDTH;
   localparam int PW = 2 * W;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_P1   = 5'b00010,
      S_P2   = 5'b00100,
      S_P3   = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] op_ff;
   logic [W-1:0] n1_ff, d1_ff, n2_ff, d2_ff;
   logic sn1_ff, sd1_ff, sn2_ff, sd2_ff;
   logic [PW-1:0] pa_ff, pb_ff, pc_ff;
   logic na_ff, nb_ff, nc_ff;
   logic [W-1:0] ma, mb;
   logic mneg;
   logic [PW-1:0] prod;

   // Magnitude of a sign-extended operand; the most negative value keeps its bits.
   function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
      mag_of = v[W-1] ? (~v + 1'b1) : v;
   endfunction

   // One shared multiplier; operand choice follows the state and opcode.
   always_comb begin
      ma = n1_ff; mb = d2_ff; mneg = sn1_ff ^ sd2_ff;
      case (state_ff)
         S_P1: begin
            if (op_ff == OP_MUL) begin
               mb = n2_ff; mneg = sn1_ff ^ sn2_ff;
            end
         end
         S_P2: begin
            if (op_ff == OP_DIV) begin
               ma = d1_ff; mb = n2_ff; mneg = sd1_ff ^ sn2_ff;
            end else begin
               ma = d1_ff; mb = d2_ff; mneg = sd1_ff ^ sd2_ff;
            end
         end
         S_P3: begin
            ma = n2_ff; mb = d1_ff;
            mneg = sn2_ff ^ sd1_ff ^ (op_ff == OP_SUB);
         end
         default: begin
            ma = n1_ff; mb = d2_ff; mneg = sn1_ff ^ sd2_ff;
         end
      endcase
      prod = ma * mb;
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (start) state_in = S_P1;
         S_P1:   state_in = S_P2;
         S_P2:   state_in = (op_ff == OP_ADD || op_ff == OP_SUB) ? S_P3 : S_OUT;
         S_P3:   state_in = S_OUT;
         S_OUT:  if (out_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Operand capture and partial products.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         op_ff <= req_opcode;
         n1_ff <= mag_of(req_left_num);  sn1_ff <= req_left_num[W-1];
         d1_ff <= mag_of(req_left_den);  sd1_ff <= req_left_den[W-1];
         n2_ff <= mag_of(req_right_num); sn2_ff <= req_right_num[W-1];
         d2_ff <= mag_of(req_right_den); sd2_ff <= req_right_den[W-1];
      end
      if (state_ff == S_P1) begin
         pa_ff <= prod; na_ff <= mneg;
      end
      if (state_ff == S_P2) begin
         pb_ff <= prod; nb_ff <= mneg;
      end
      if (state_ff == S_P3) begin
         pc_ff <= prod; nc_ff <= mneg;
      end
   end

   // Signed magnitude sum for add and subtract.
   logic [PW:0] sum_mag;
   logic sum_neg;
   logic [PW:0] ea, ec;
   always_comb begin
      ea = {1'b0, pa_ff};
      ec = {1'b0, pc_ff};
      if (na_ff == nc_ff) begin
         sum_mag = ea + ec; sum_neg = na_ff;
      end else if (ea >= ec) begin
         sum_mag = ea - ec; sum_neg = na_ff;
      end else begin
         sum_mag = ec - ea; sum_neg = nc_ff;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign out_valid = (state_ff == S_OUT);
   assign out_num_mag = (op_ff == OP_ADD || op_ff == OP_SUB) ? sum_mag : {1'b0, pa_ff};
   assign out_num_neg = (op_ff == OP_ADD || op_ff == OP_SUB) ? sum_neg : na_ff;
   assign out_den_mag = pb_ff;
   assign out_den_neg = nb_ff;
   assign out_err = (d1_ff == '0) || (d2_ff == '0) || (pb_ff == '0);
endmodule
`default_nettype wire

// ===== rtl/core/ralu_queue.sv =====
// ---------------------------------------------------------------------------
// ralu_queue
// Small register queue carrying classified words from front to back part.
// ---------------------------------------------------------------------------
`default_nettype none
module ralu_queue #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH = ralu_pkg::QueueDepth
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [DATA_WIDTH-1:0] in_data,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [DATA_WIDTH-1:0]      out_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0] cnt_ff;
   logic push, pop;

   assign in_ready = (cnt_ff != DEPTH[AW:0]);
   assign out_valid = (cnt_ff != '0);
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign out_data = mem_ff[rd_ff];

   // Pointer and fill count update.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_data;
   end
endmodule
`default_nettype wire

// ===== rtl/core/ralu_back.sv =====
// ---------------------------------------------------------------------------
// ralu_back
// Binary gcd over the magnitudes, then two restoring divisions by the gcd,
// one quotient bit per cycle, and the signed result strobe.
// ---------------------------------------------------------------------------
`default_nettype none
module ralu_back #(
   parameter int OPERAND_WIDTH = ralu_pkg::OperandWidthDefault
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic [2*OPERAND_WIDTH:0]   in_num_mag,
   input  wire logic                       in_num_neg,
   input  wire logic [2*OPERAND_WIDTH-1:0] in_den_mag,
   input  wire logic                       in_den_neg,
   input  wire logic                       in_err,
   output logic                            rsp_valid,
   output logic [ralu_pkg::NumWidth-1:0]   rsp_result_num,
   output logic [ralu_pkg::DenWidth-1:0]   rsp_result_den,
   output logic                            rsp_status
);
   import ralu_pkg::*;
   localparam int MW = 2 * OPERAND_WIDTH + 1;
   localparam int CW = $clog2(MW + 1);

   typedef enum logic [5:0] {
      B_IDLE  = 6'b000001,
      B_TWO   = 6'b000010,
      B_GCD   = 6'b000100,
      B_DIVN  = 6'b001000,
      B_DIVD  = 6'b010000,
      B_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [MW-1:0] num_ff, den_ff, ga_ff, gb_ff, g_ff;
   logic [MW-1:0] quo_ff, rem_ff, dvd_ff, qn_ff;
   logic [CW-1:0] k_ff, bit_ff;
   logic neg_ff, err_ff, zero_ff;

   // Remainder step of the restoring division.
   logic [MW:0] trial;
   assign trial = {rem_ff, dvd_ff[MW-1]} - {1'b0, g_ff};

   // Gcd step values.
   logic [MW-1:0] gdiff;
   assign gdiff = (ga_ff > gb_ff) ? ga_ff - gb_ff : gb_ff - ga_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: if (in_valid) state_in = (in_err || in_num_mag == '0) ? B_OUT : B_TWO;
         B_TWO:  if (ga_ff[0] || gb_ff[0]) state_in = B_GCD;
         B_GCD:  if (gb_ff == '0) state_in = B_DIVN;
         B_DIVN: if (bit_ff == '0) state_in = B_DIVD;
         B_DIVD: if (bit_ff == '0) state_in = B_OUT;
         B_OUT:  state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath: strip common twos, then subtract-and-shift gcd, then divisions.
   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            if (in_valid) begin
               num_ff <= in_num_mag;
               den_ff <= {1'b0, in_den_mag};
               ga_ff <= in_num_mag;
               gb_ff <= {1'b0, in_den_mag};
               k_ff <= '0;
               neg_ff <= in_num_neg ^ in_den_neg;
               err_ff <= in_err;
               zero_ff <= (in_num_mag == '0);
            end
         end
         B_TWO: begin
            if (!(ga_ff[0] || gb_ff[0])) begin
               ga_ff <= ga_ff >> 1; gb_ff <= gb_ff >> 1; k_ff <= k_ff + 1'b1;
            end else if (!ga_ff[0]) begin
               ga_ff <= gb_ff; gb_ff <= ga_ff;
            end
         end
         B_GCD: begin
            // ga stays odd; gb holds the other value, halved until odd.
            if (gb_ff == '0) begin
               g_ff <= ga_ff << k_ff;
               rem_ff <= '0; dvd_ff <= num_ff; bit_ff <= CW'(MW - 1);
            end else if (!gb_ff[0]) begin
               gb_ff <= gb_ff >> 1;
            end else begin
               ga_ff <= (ga_ff < gb_ff) ? ga_ff : gb_ff;
               gb_ff <= gdiff;
            end
         end
         B_DIVN, B_DIVD: begin
            quo_ff <= {quo_ff[MW-2:0], ~trial[MW]};
            if (bit_ff == '0) begin
               // Last quotient bit; set up the second division.
               rem_ff <= '0; dvd_ff <= den_ff; bit_ff <= CW'(MW - 1);
               if (state_ff == B_DIVN) qn_ff <= {quo_ff[MW-2:0], ~trial[MW]};
            end else begin
               if (!trial[MW]) begin
                  rem_ff <= trial[MW-1:0];
               end else begin
                  rem_ff <= {rem_ff[MW-2:0], dvd_ff[MW-1]};
               end
               dvd_ff <= dvd_ff << 1;
               bit_ff <= bit_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Result forming.
   logic [MW-1:0] qd;
   assign qd = quo_ff;
   logic [NumWidth-1:0] qn_cut;
   assign qn_cut = NumWidth'(qn_ff);
   always_comb begin
      if (err_ff) begin
         rsp_result_num = '0; rsp_result_den = '0; rsp_status = STATUS_ZERO_DEN;
      end else if (zero_ff) begin
         rsp_result_num = '0; rsp_result_den = DenWidth'(1); rsp_status = STATUS_OK;
      end else begin
         rsp_result_num = neg_ff ? (~qn_cut + 1'b1) : qn_cut;
         rsp_result_den = DenWidth'(qd);
         rsp_status = STATUS_OK;
      end
   end

   assign rsp_valid = (state_ff == B_OUT);
   assign in_ready = (state_ff == B_IDLE);
endmodule
`default_nettype wire

// ===== rtl/core/ralu_checker.sv =====
// ---------------------------------------------------------------------------
// ralu_checker
// Port-level checks of the rational unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module ralu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [32:0] rsp_result_num,
   input wire logic [31:0] rsp_result_den,
   input wire logic        rsp_status
);
   // An accepted word makes the unit busy next cycle.
   `ASSERT_CLK(a_busy_after_start, clock, reset, (start && !busy) |=> busy)
   // An error result carries 0/0.
   `ASSERT_CLK(a_err_zero, clock, reset, (rsp_valid && rsp_status) |-> (rsp_result_num == '0 && rsp_result_den == '0))
   // A good result has a nonzero denominator.
   `ASSERT_CLK(a_den_pos, clock, reset, (rsp_valid && !rsp_status) |-> (rsp_result_den != '0))
   // Results come as single-cycle strobes.
   `ASSERT_CLK(a_strobe, clock, reset, rsp_valid |=> !rsp_valid)
endmodule

bind rational_alu_reduced_unit ralu_checker u_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_result_num(rsp_result_num),
   .rsp_result_den(rsp_result_den), .rsp_status(rsp_status)
);
`default_nettype wire

// ===== tb/rational_alu_reduced_unit_tb.sv =====
// ---------------------------------------------------------------------------
// rational_alu_reduced_unit_tb
// Drives fraction pairs with every opcode into the unit, predicts the reduced
// result of each accepted word and checks every strobed result in order.
// ---------------------------------------------------------------------------
`default_nettype none
module rational_alu_reduced_unit_tb;
   import ralu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = OperandWidthDefault;

   typedef struct packed {
      opcode_type       op;
      logic [W-1:0]     ln;
      logic [W-1:0]     ld;
      logic [W-1:0]     rn;
      logic [W-1:0]     rd;
   } frac_word_t;

   typedef struct packed {
      logic [NumWidth-1:0] num;
      logic [DenWidth-1:0] den;
      logic                status;
   } reduced_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_opcode = '0;
   logic [W-1:0] req_left_num = '0, req_left_den = '0;
   logic [W-1:0] req_right_num = '0, req_right_den = '0;
   logic rsp_valid;
   logic [NumWidth-1:0] rsp_result_num;
   logic [DenWidth-1:0] rsp_result_den;
   logic rsp_status;

   frac_word_t pending_words[$];
   reduced_t   expected_fracs[$];
   int         mismatches = 0;
   bit         stim_done = 1'b0;
   int         gap = 0;

   rational_alu_reduced_unit dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Binary-free Euclid on magnitudes.
   function automatic longint unsigned gcd_mag(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // Computes the reduced fraction for one word, with sign on the numerator.
   function automatic reduced_t reduce_fraction(frac_word_t w);
      longint n1, d1, n2, d2, num, den;
      longint unsigned g, mn, md;
      reduced_t r;
      n1 = longint'($signed(w.ln));
      d1 = longint'($signed(w.ld));
      n2 = longint'($signed(w.rn));
      d2 = longint'($signed(w.rd));
      case (w.op)
         OP_ADD: begin num = n1 * d2 + n2 * d1; den = d1 * d2; end
         OP_SUB: begin num = n1 * d2 - n2 * d1; den = d1 * d2; end
         OP_MUL: begin num = n1 * n2; den = d1 * d2; end
         default: begin num = n1 * d2; den = d1 * n2; end
      endcase
      r = '0;
      if (d1 == 0 || d2 == 0 || den == 0) begin
         r.status = STATUS_ZERO_DEN;
      end else if (num == 0) begin
         r.den = 1;
      end else begin
         mn = (num < 0) ? -num : num;
         md = (den < 0) ? -den : den;
         g = gcd_mag(mn, md);
         mn = mn / g;
         md = md / g;
         r.num = ((num < 0) != (den < 0)) ? NumWidth'(-mn) : NumWidth'(mn);
         r.den = DenWidth'(md);
         r.status = STATUS_OK;
      end
      return r;
   endfunction

   function automatic logic [W-1:0] rand_operand();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return {1'b1, {(W-1){1'b0}}};
         2: return {1'b0, {(W-1){1'b1}}};
         3: return W'($urandom_range(0, 8)) - W'(4);
         4, 5: return W'($urandom_range(0, 60)) - W'(30);
         default: return W'($urandom);
      endcase
   endfunction

   task automatic add_word(opcode_type op, logic [W-1:0] ln, logic [W-1:0] ld,
                           logic [W-1:0] rn, logic [W-1:0] rd);
      pending_words.push_back('{op, ln, ld, rn, rd});
   endtask

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // Stimulus: directed corner words, then random fractions mixing corner, small and full-range operands.
   initial begin
      logic [W-1:0] mn, mx;
      mn = {1'b1, {(W-1){1'b0}}};
      mx = {1'b0, {(W-1){1'b1}}};
      for (int o = 0; o < 4; o++) begin
         add_word(opcode_type'(o), 16'd1, 16'd2, 16'd1, 16'd3);
         add_word(opcode_type'(o), mn, mn, mn, mn);
         add_word(opcode_type'(o), mx, mn, mn, mx);
      end
      add_word(OP_ADD, 16'd3, 16'd0, 16'd1, 16'd2);
      add_word(OP_MUL, 16'd3, 16'd4, 16'd1, 16'd0);
      add_word(OP_DIV, 16'd3, 16'd4, 16'd0, 16'd5);
      add_word(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
      add_word(OP_MUL, 16'd0, 16'd7, 16'd5, 16'd3);
      add_word(OP_ADD, -16'sd3, 16'd4, 16'd1, -16'sd6);
      add_word(OP_DIV, -16'sd2, -16'sd3, 16'd4, -16'sd9);
      add_word(OP_MUL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_word(OP_ADD, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
      for (int i = 0; i < 750; i++)
         add_word(opcode_type'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                  rand_operand(), rand_operand());
      stim_done = 1'b1;
   end

   // Driver: presents the next word and holds it until accepted.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         void'(pending_words.pop_front());
         expected_fracs.push_back(reduce_fraction('{opcode_type'(req_opcode), req_left_num,
            req_left_den, req_right_num, req_right_den}));
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 300) : $urandom_range(0, 3);
         if ($urandom_range(0, 3) == 0) gap = 0;
         // Back to back when no gap is drawn, otherwise drop start.
         if (gap == 0 && pending_words.size() > 0) begin
            {req_opcode, req_left_num, req_left_den, req_right_num, req_right_den}
               <= pending_words[0];
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (gap > 0) begin
            gap--;
         end else if (pending_words.size() > 0) begin
            start <= 1'b1;
            {req_opcode, req_left_num, req_left_den, req_right_num, req_right_den}
               <= pending_words[0];
         end
      end
   end

   // Monitor: checks each strobed result against the oldest expectation.
   always @(posedge clock) begin
      reduced_t want;
      if (!reset && rsp_valid) begin
         if (expected_fracs.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_result_num), 64'd0);
         end else begin
            want = expected_fracs.pop_front();
            if (rsp_result_num !== want.num)
               report_mismatch("num", 64'(rsp_result_num), 64'(want.num));
            if (rsp_result_den !== want.den)
               report_mismatch("den", 64'(rsp_result_den), 64'(want.den));
            if (rsp_status !== want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
         end
      end
   end

   // Reset, then wait for the stimulus to drain and the last results to land.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done);
      while (pending_words.size() > 0 || start || expected_fracs.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0) begin
         $display("rational_alu_reduced_unit verification clean");
      end else begin
         $display("rational_alu_reduced_unit verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5000000;
      $display("rational_alu_reduced_unit verification failed");
      $finish;
   end
endmodule
`default_nettype wire

// ===== rational_alu_reduced_unit.f =====
+incdir+rtl/core
rtl/core/ralu_pkg.sv
rtl/core/ralu_front.sv
rtl/core/ralu_queue.sv
rtl/core/ralu_back.sv
rtl/core/rational_alu_reduced_unit.sv
rtl/core/ralu_checker.sv
tb/rational_alu_reduced_unit_tb.sv
